[hdl/aliq_pkg.sv]
// Package for the aliquot sum unit: widths, class codes and the
// command/status structs between controller and datapath.
// No dependencies.
package aliq_pkg;

    localparam int NUM_BITS = 16;
    localparam int SUM_BITS = 20;
    localparam int CLASS_BITS = 2;
    localparam int VALUE_BITS_DEFAULT = 16;

    localparam logic [CLASS_BITS-1:0] CLASS_DEFICIENT = 2'd0;
    localparam logic [CLASS_BITS-1:0] CLASS_PERFECT = 2'd1;
    localparam logic [CLASS_BITS-1:0] CLASS_ABUNDANT = 2'd2;

    typedef struct packed {
        logic load;
        logic div_start;
        logic accum;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic below_two;
        logic in_range;
        logic div_done;
    } dp_stat_t;

endpackage

[hdl/aliquot_sum_unit.sv]
// Top level of the aliquot sum unit: controller plus datapath.
// Depends on aliq_pkg, aliq_ctrl and aliq_datapath.
//
// Usage:
// - Raise start with number_in valid while busy is low; the item is taken
//   at that clock edge and busy goes high on the next cycle.
// - When the item is finished, done is high for exactly one cycle with
//   aliquot_sum and number_class valid; the receiver cannot stall, so it
//   must capture the result in that cycle. The result ports then hold
//   their value until the next item completes.
// - Only the low VALUE_BITS bits of number_in are used (at most 16).
// - Each trial divisor t with t*t <= n costs a check step plus a division in
//   the shared bit-serial divider, so an item runs floor(sqrt(n)) divisions;
//   n = 0 and n = 1 skip the divider.
// - busy drops in the cycle done is high, so the next item can be given
//   then; one item is in work at a time.
// - Reset (rst_n low, asynchronous) returns the controller to idle and
//   clears done; an item in work is dropped.
module aliquot_sum_unit #(
    parameter int VALUE_BITS = aliq_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [aliq_pkg::NUM_BITS-1:0]       number_in,
    output logic                                done,
    output logic [aliq_pkg::SUM_BITS-1:0]       aliquot_sum,
    output logic [aliq_pkg::CLASS_BITS-1:0]     number_class
);

    aliq_pkg::dp_cmd_t  cmd;
    aliq_pkg::dp_stat_t stat;

    aliq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    aliq_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .number_in    (number_in),
        .aliquot_sum  (aliquot_sum),
        .number_class (number_class)
    );

    // A finished item always leaves the unit ready for the next one.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    // An accepted item keeps the unit busy on the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted item did not make the unit busy");

    // A perfect number has a nonzero divisor sum.
    a_perfect_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (done && number_class == aliq_pkg::CLASS_PERFECT) |-> (aliquot_sum != '0))
        else $error("perfect class with zero sum");

endmodule

[hdl/aliq_div.sv]
// Restoring bit-serial divider: one quotient bit per cycle.
// Uses no package items.
module aliq_div #(
    parameter int W = 16,
    parameter int DW = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [W-1:0]  dividend,
    input  logic [DW-1:0] divisor,
    output logic [W-1:0]  quotient,
    output logic [DW-1:0] remainder,
    output logic          done
);

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          fits;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff = shifted - {1'b0, divisor};
    assign fits = shifted >= {1'b0, divisor};

    always_comb
    begin
        cnt_next = cnt_reg;
        done_next = 1'b0;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = CW'(W);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
            quo_next = {quo_reg[W-2:0], fits};
            // The remainder always stays below the divisor, so DW bits hold it.
            rem_next = fits ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    assign remainder = rem_reg;
    assign done = done_reg;

endmodule

[hdl/aliq_datapath.sv]
// Datapath: number, trial divisor, running divisor sum, result registers.
// Depends on aliq_pkg and aliq_div.
module aliq_datapath #(
    parameter int VALUE_BITS = aliq_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  aliq_pkg::dp_cmd_t                      cmd,
    output aliq_pkg::dp_stat_t                     stat,
    input  logic [aliq_pkg::NUM_BITS-1:0]          number_in,
    output logic [aliq_pkg::SUM_BITS-1:0]          aliquot_sum,
    output logic [aliq_pkg::CLASS_BITS-1:0]        number_class
);

    localparam int NW = (VALUE_BITS < aliq_pkg::NUM_BITS) ? VALUE_BITS : aliq_pkg::NUM_BITS;
    localparam int TW = NW / 2 + 1;
    localparam int QW = 2 * TW;
    localparam int SW = NW + 4;
    localparam int SB = aliq_pkg::SUM_BITS;

    logic [NW-1:0] n_reg;
    logic [TW-1:0] t_reg;
    logic [SW-1:0] total_reg;
    logic [SB-1:0] sum_reg;
    logic [aliq_pkg::CLASS_BITS-1:0] class_reg;

    logic [QW-1:0] t_sq;
    logic [NW-1:0] quotient;
    logic [TW-1:0] remainder;
    logic          div_done;
    logic [SW-1:0] partner_add;
    logic [SW-1:0] proper;
    logic [SW-1:0] n_ext;

    aliq_div #(
        .W  (NW),
        .DW (TW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (n_reg),
        .divisor   (t_reg),
        .quotient  (quotient),
        .remainder (remainder),
        .done      (div_done)
    );

    assign t_sq = QW'(t_reg) * QW'(t_reg);
    assign n_ext = SW'(n_reg);

    assign stat.below_two = (n_reg < NW'(2));
    assign stat.in_range = (t_sq <= QW'(n_reg));
    assign stat.div_done = div_done;

    // The partner n/t is counted only when it differs from t itself.
    assign partner_add = (quotient != NW'(t_reg)) ? SW'(quotient) : '0;
    assign proper = stat.below_two ? '0 : (total_reg - n_ext);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= number_in[NW-1:0];
            t_reg <= TW'(1);
            total_reg <= '0;
        end
        else if (cmd.accum)
        begin
            t_reg <= t_reg + 1'b1;
            if (remainder == '0)
            begin
                total_reg <= total_reg + SW'(t_reg) + partner_add;
            end
        end
        if (cmd.finish)
        begin
            sum_reg <= SB'(proper);
            if (stat.below_two || proper < n_ext)
            begin
                class_reg <= aliq_pkg::CLASS_DEFICIENT;
            end
            else if (proper == n_ext)
            begin
                class_reg <= aliq_pkg::CLASS_PERFECT;
            end
            else
            begin
                class_reg <= aliq_pkg::CLASS_ABUNDANT;
            end
        end
    end

    assign aliquot_sum = sum_reg;
    assign number_class = class_reg;

endmodule

[hdl/aliq_ctrl.sv]
// Controller: sequences trial divisors through the datapath for one item.
// Depends on aliq_pkg.
module aliq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  aliq_pkg::dp_stat_t stat,
    output aliq_pkg::dp_cmd_t  cmd,
    output logic               busy,
    output logic               done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next = 1'b0;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.below_two || !stat.in_range)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.accum = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

[tb/aliquot_sum_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for aliquot_sum_unit: predicts the proper divisor sum and class
// for every number taken and compares each done strobe with the oldest prediction.
// Depends on aliq_pkg and the aliquot_sum_unit RTL.
module aliquot_sum_unit_test;

    localparam int NUM_BITS = aliq_pkg::NUM_BITS;
    localparam int SUM_BITS = aliq_pkg::SUM_BITS;
    localparam int CLASS_BITS = aliq_pkg::CLASS_BITS;
    localparam int VALUE_BITS = aliq_pkg::VALUE_BITS_DEFAULT;
    localparam int RANDOM_ITEMS = 118;
    localparam int SETTLE_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint SUM_CEILING = (longint'(1) << SUM_BITS) - 1;

    typedef struct {
        logic [NUM_BITS-1:0] number;
        int unsigned         gap;
        bit                  drain;
    } number_item_t;

    typedef struct {
        logic [NUM_BITS-1:0]   number;
        logic [SUM_BITS-1:0]   sum;
        logic [CLASS_BITS-1:0] cls;
    } divisor_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [NUM_BITS-1:0]   number_in = '0;
    logic                  busy;
    logic                  done;
    logic [SUM_BITS-1:0]   aliquot_sum;
    logic [CLASS_BITS-1:0] number_class;

    number_item_t    pending_items [$];
    divisor_result_t awaited_results [$];
    number_item_t    held_item;
    bit              have_item = 1'b0;
    int unsigned     gap_left = 0;
    int              accepted_count = 0;
    int              result_count = 0;
    int              mismatch_count = 0;
    int              calm_left = 0;
    int              class_tally [0:3] = '{0, 0, 0, 0};
    longint          cycle_count = 0;

    aliquot_sum_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .number_in(number_in),
        .done(done),
        .aliquot_sum(aliquot_sum),
        .number_class(number_class)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Trial division up to the integer square root, then the number itself comes off.
    function automatic divisor_result_t predict_divisors(input logic [NUM_BITS-1:0] raw);
        longint n;
        longint total;
        longint t;
        longint partner;
        divisor_result_t r;
        n = longint'(raw) & ((longint'(1) << VALUE_BITS) - 1);
        total = 0;
        if (n >= 2)
        begin
            for (t = 1; t * t <= n; t++)
            begin
                if (n % t == 0)
                begin
                    partner = n / t;
                    total += t;
                    if (partner != t)
                        total += partner;
                end
            end
            total -= n;
        end
        r.number = raw;
        r.sum = SUM_BITS'((total > SUM_CEILING) ? SUM_CEILING : total);
        if (n == 0 || total < n)
            r.cls = aliq_pkg::CLASS_DEFICIENT;
        else if (total == n)
            r.cls = aliq_pkg::CLASS_PERFECT;
        else
            r.cls = aliq_pkg::CLASS_ABUNDANT;
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run of items with none.
    function automatic int unsigned idle_cycles();
        int pick;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            calm_left = $urandom_range(8, 20);
            return 0;
        end
        if (pick < 45)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : drive_numbers
        bit raise;
        bit took;
        raise = 1'b0;
        took = 1'b0;
        if (rst_n)
        begin
            took = start && !busy;
            if (took)
            begin
                awaited_results.push_back(predict_divisors(number_in));
                accepted_count <= accepted_count + 1;
            end
            else
            begin
                raise = start;
            end
            if (!raise)
            begin
                if (!have_item && pending_items.size() != 0)
                begin
                    held_item = pending_items.pop_front();
                    have_item = 1'b1;
                    gap_left = held_item.gap;
                end
                if (have_item)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    else if (!held_item.drain || accepted_count + int'(took) == result_count)
                    begin
                        raise = 1'b1;
                        have_item = 1'b0;
                        number_in <= held_item.number;
                    end
                end
                // The number port carries noise while no item is offered.
                if (!raise)
                    number_in <= NUM_BITS'($urandom);
            end
            start <= raise;
        end
    end

    always @(posedge clk)
    begin : check_results
        divisor_result_t want;
        if (rst_n && done)
        begin
            result_count <= result_count + 1;
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("result with no item in flight: sum %0d class %0d",
                                          aliquot_sum, number_class));
            end
            else
            begin
                want = awaited_results.pop_front();
                class_tally[want.cls]++;
                if (aliquot_sum !== want.sum)
                    report_mismatch($sformatf("n=%0d aliquot_sum %0d, want %0d",
                                              want.number, aliquot_sum, want.sum));
                if (number_class !== want.cls)
                    report_mismatch($sformatf("n=%0d number_class %0d, want %0d",
                                              want.number, number_class, want.cls));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [NUM_BITS-1:0] directed_numbers [$];
        logic [NUM_BITS-1:0] val;
        number_item_t item;
        int k;
        int pick;
        int root;
        // Zero and one, small primes, a square, the perfect numbers that fit, odd and even
        // abundant numbers, the largest square, a large prime and bit patterns at the top.
        directed_numbers = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd9, 16'd12,
                             16'd28, 16'd496, 16'd8128, 16'd945, 16'd32768, 16'd65025,
                             16'd65521, 16'd65534, 16'd65535, 16'hAAAA, 16'h5555,
                             16'h8001, 16'd1, 16'd0};
        foreach (directed_numbers[i])
        begin
            item.number = directed_numbers[i];
            item.gap = idle_cycles();
            item.drain = 1'b0;
            pending_items.push_back(item);
        end
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                val = NUM_BITS'($urandom_range(0, 1023));
            end
            else if (pick < 70)
            begin
                val = NUM_BITS'($urandom_range(1024, 8191));
            end
            else if (pick < 80)
            begin
                // Exact squares and their neighbors hit the case where the divisor
                // equals its partner.
                root = $urandom_range(1, 255);
                val = NUM_BITS'(root * root - 1 + $urandom_range(0, 2));
            end
            else if (pick < 88)
            begin
                case ($urandom_range(0, 5))
                    0: val = 16'd6;
                    1: val = 16'd28;
                    2: val = 16'd496;
                    3: val = 16'd8128;
                    4: val = 16'd5040;
                    default: val = 16'd720;
                endcase
            end
            else
            begin
                val = NUM_BITS'($urandom_range(0, 65535));
            end
            item.number = val;
            item.gap = idle_cycles();
            item.drain = (k == 0) || ($urandom_range(0, 49) == 0);
            pending_items.push_back(item);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Sampling at the falling edge sees the driver's updates from the rising edge.
        while (pending_items.size() != 0 || have_item || start
               || accepted_count != result_count)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

        $display("Checked %0d numbers: %0d deficient, %0d perfect, %0d abundant.",
                 result_count, class_tally[aliq_pkg::CLASS_DEFICIENT],
                 class_tally[aliq_pkg::CLASS_PERFECT], class_tally[aliq_pkg::CLASS_ABUNDANT]);
        $display("Run took %0d cycles with %0d mismatches.", cycle_count, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
